[src/cpts_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cpts_pkg: shared types and constants for the priority task scheduler
// Task entry layout, run state and function codes, sequencer states.
// ----------------------------------------------------------------------------
package cpts_pkg;

  localparam int unsigned TASKS_DEFAULT    = 64;
  localparam int unsigned TASK_W           = 6;
  localparam int unsigned RUN_W            = 2;
  localparam int unsigned PRIO_W           = 6;
  localparam int unsigned COUNT_W          = 7;
  localparam int unsigned DATA_W           = 32;
  localparam int unsigned ALARM_SIGNAL_BIT = 13;

  localparam logic [DATA_W-1:0] ALARM_MASK = DATA_W'(1) << ALARM_SIGNAL_BIT;
  localparam logic [PRIO_W-1:0] PRIO_MIN   = PRIO_W'(1);

  localparam logic FUNC_WRITE    = 1'b0;
  localparam logic FUNC_SCHEDULE = 1'b1;

  localparam logic [RUN_W-1:0] RUN_RUNNING       = 2'd0;
  localparam logic [RUN_W-1:0] RUN_INTERRUPTIBLE = 2'd1;

  typedef struct packed {
    logic              present;
    logic [RUN_W-1:0]  run_state;
    logic [PRIO_W-1:0] prio;
    logic [COUNT_W-1:0] count;
    logic [DATA_W-1:0] alarm;
    logic [DATA_W-1:0] signals;
  } entry_t;

  localparam entry_t RESET_ENTRY = '{
    present:   1'b0,
    run_state: RUN_RUNNING,
    prio:      PRIO_MIN,
    count:     '0,
    alarm:     '0,
    signals:   '0
  };

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_REFILL,
    S_DONE
  } state_t;

endpackage : cpts_pkg
`default_nettype wire

[src/cpts_table.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cpts_table: task table memory
// One write and one registered read port; entries never written read as the
// reset entry through a row of valid bits cleared by reset.
// ----------------------------------------------------------------------------
module cpts_table
  import cpts_pkg::*;
#(
  parameter int unsigned TASKS = TASKS_DEFAULT,
  localparam int unsigned IDX_W = $clog2(TASKS)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  output entry_t                rd_data,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire entry_t           wr_data
);

  entry_t           mem [TASKS];
  logic [TASKS-1:0] vld;
  entry_t           mem_q;
  logic             vld_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= 1'b0;
    end else if (rd_en) begin
      vld_q <= vld[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  assign rd_data = vld_q ? mem_q : RESET_ENTRY;

endmodule : cpts_table
`default_nettype wire

[src/counter_priority_task_scheduler.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// counter_priority_task_scheduler: counter-based priority task scheduler
// Task table with alarm wake-up, largest-counter selection and counter refill.
// ----------------------------------------------------------------------------
// A write beat (func 0) loads one task entry and gives no result. A schedule
// beat (func 1) walks task entries 1 to TASKS-1 through the table's single
// read port, one entry per cycle: the first pass expires alarms, wakes
// signalled tasks and selects; when the winner's counter is zero a refill
// pass with reselection follows. Reset takes effect at once: the table
// has a valid bit per entry, so no clearing pass is needed. A finished result
// waits in the output register while the next beat is accepted.
// ----------------------------------------------------------------------------
module counter_priority_task_scheduler
  import cpts_pkg::*;
#(
  parameter int unsigned TASKS = TASKS_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               func,
  input  wire logic [TASK_W-1:0]  task_index,
  input  wire logic               present,
  input  wire logic [RUN_W-1:0]   run_state,
  input  wire logic [PRIO_W-1:0]  priority_req,
  input  wire logic [COUNT_W-1:0] slice_count,
  input  wire logic [DATA_W-1:0]  alarm_time,
  input  wire logic [DATA_W-1:0]  signal_bits,
  input  wire logic [DATA_W-1:0]  now,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [TASK_W-1:0]       next_task,
  output logic [COUNT_W-1:0]      chosen_count,
  output logic                    idle_chosen,
  output logic                    refilled
);

  localparam int unsigned IDX_W = $clog2(TASKS);
  localparam int unsigned CNT_W = $clog2(TASKS + 1);

  state_t             state, state_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic               proc_valid, proc_valid_next;
  logic [IDX_W-1:0]   proc_addr;
  logic [DATA_W-1:0]  now_q, now_q_next;
  logic [IDX_W-1:0]   best, best_next;
  logic [COUNT_W-1:0] best_count, best_count_next;
  logic               best_found, best_found_next;
  logic [IDX_W-1:0]   res_task, res_task_next;
  logic [COUNT_W-1:0] res_count, res_count_next;
  logic               res_idle, res_idle_next;
  logic               res_refilled, res_refilled_next;
  logic               out_valid_next;
  logic               out_load;

  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  entry_t             rd_data;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;

  entry_t             in_ent;
  entry_t             scan_ent;
  entry_t             refill_ent;
  entry_t             upd;
  logic               idx_ok;
  logic               issue;
  logic               pass_end;
  logic               cand;
  logic               out_free;

  cpts_table #(
    .TASKS (TASKS)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  always_comb begin
    in_ent.present   = present;
    in_ent.run_state = run_state;
    in_ent.prio      = (priority_req == '0) ? PRIO_MIN : priority_req;
    in_ent.count     = slice_count;
    in_ent.alarm     = alarm_time;
    in_ent.signals   = signal_bits;
  end

  assign idx_ok = ({{(32 - TASK_W){1'b0}}, task_index} < 32'(TASKS));

  // expire alarm, then wake a signalled interruptible task
  always_comb begin
    scan_ent = rd_data;
    if ((rd_data.alarm != '0) && (rd_data.alarm < now_q)) begin
      scan_ent.signals = rd_data.signals | ALARM_MASK;
      scan_ent.alarm   = '0;
    end
    if ((scan_ent.signals != '0) && (scan_ent.run_state == RUN_INTERRUPTIBLE)) begin
      scan_ent.run_state = RUN_RUNNING;
    end
  end

  always_comb begin
    refill_ent       = rd_data;
    refill_ent.count = {1'b0, rd_data.count[COUNT_W-1:1]}
                     + {{(COUNT_W - PRIO_W){1'b0}}, rd_data.prio};
  end

  assign upd      = (state == S_REFILL) ? refill_ent : scan_ent;
  assign cand     = upd.present && (upd.run_state == RUN_RUNNING);
  assign issue    = (cnt < CNT_W'(TASKS));
  assign pass_end = (cnt == CNT_W'(TASKS)) && !proc_valid;
  assign rd_addr  = cnt[IDX_W-1:0];
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      proc_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      proc_valid <= proc_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt          <= cnt_next;
    proc_addr    <= rd_addr;
    now_q        <= now_q_next;
    best         <= best_next;
    best_count   <= best_count_next;
    best_found   <= best_found_next;
    res_task     <= res_task_next;
    res_count    <= res_count_next;
    res_idle     <= res_idle_next;
    res_refilled <= res_refilled_next;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      next_task    <= TASK_W'(res_task);
      chosen_count <= res_count;
      idle_chosen  <= res_idle;
      refilled     <= res_refilled;
    end
  end

  always_comb begin
    state_next        = state;
    cnt_next          = cnt;
    proc_valid_next   = 1'b0;
    now_q_next        = now_q;
    best_next         = best;
    best_count_next   = best_count;
    best_found_next   = best_found;
    res_task_next     = res_task;
    res_count_next    = res_count;
    res_idle_next     = res_idle;
    res_refilled_next = res_refilled;
    out_valid_next    = out_valid && out_stall;
    out_load          = 1'b0;
    in_stall          = (state != S_IDLE);
    rd_en             = 1'b0;
    wr_en             = 1'b0;
    wr_addr           = proc_addr;
    wr_data           = upd;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (func == FUNC_WRITE) begin
            wr_en   = idx_ok;
            wr_addr = IDX_W'(task_index);
            wr_data = in_ent;
          end else begin
            state_next        = S_SCAN;
            cnt_next          = CNT_W'(1);
            now_q_next        = now;
            best_found_next   = 1'b0;
            res_refilled_next = 1'b0;
          end
        end
      end
      S_SCAN, S_REFILL: begin
        rd_en           = issue;
        proc_valid_next = issue;
        if (issue) begin
          cnt_next = cnt + CNT_W'(1);
        end
        if (proc_valid) begin
          wr_en = upd.present;
          if (cand && (!best_found || (upd.count >= best_count))) begin
            best_next       = proc_addr;
            best_count_next = upd.count;
            best_found_next = 1'b1;
          end
        end
        if (pass_end) begin
          if (best_found && (best_count == '0) && (state == S_SCAN)) begin
            state_next        = S_REFILL;
            cnt_next          = CNT_W'(1);
            best_found_next   = 1'b0;
            res_refilled_next = 1'b1;
          end else begin
            state_next     = S_DONE;
            res_task_next  = best_found ? best : '0;
            res_count_next = best_found ? best_count : '0;
            res_idle_next  = !best_found;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_no_same_entry_clash: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && wr_en && (rd_addr == wr_addr)))
    else $error("table read and write hit the same entry");

  a_refill_finds_winner: assert property (@(posedge clk) disable iff (rst)
    (state == S_REFILL) && pass_end |-> best_found)
    else $error("refill pass ended without a running task");

  a_refill_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_load && res_refilled |-> !res_idle && (res_count != '0))
    else $error("refilled decision gave a zero counter");

  a_proc_only_in_pass: assert property (@(posedge clk) disable iff (rst)
    proc_valid |-> (state == S_SCAN) || (state == S_REFILL))
    else $error("entry in flight outside a table pass");

  a_result_waits_for_room: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> !$past(out_load))
    else $error("output overwritten while stalled");

endmodule : counter_priority_task_scheduler
`default_nettype wire
